// ===== sv/flash_line_cache_fifo_unit_macros.svh =====
// Assertion macros shared by the flash line cache modules.
// Both forms take a label, clock, reset, antecedent and consequent.
// FLCF_ASSERT checks the consequent in the same cycle as the antecedent.
// FLCF_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef FLASH_LINE_CACHE_FIFO_UNIT_MACROS_SVH
`define FLASH_LINE_CACHE_FIFO_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FLCF_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flcf check failed");
`define FLCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flcf check failed");
`else
`define FLCF_ASSERT(label, clk, rst, ante, cons)
`define FLCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/flcf_pkg.sv =====
package flcf_pkg;

  localparam int LINE_COUNT_DEF = 8;
  localparam int LINE_BYTES_DEF = 32;

  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int OFFSET_W = 5;
  localparam int PADDR_W  = 3;
  localparam int MAX_READ = 4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILL_NEEDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FILL_DONE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BYPASS      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd4;

  // input modes
  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_FILL = 1'b1;

  // register indexes
  localparam logic [PADDR_W-3:0] REG_FLASH_BASE = 1'b0;

  typedef struct packed {
    logic                capture;
    logic                miss;
    logic                fill_wr;
    logic                fill_end;
    logic                hit_sel;
    logic                rd_issue;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } flcf_cmd_t;

  typedef struct packed {
    logic mode;
    logic fill_pending;
    logic out_of_range;
    logic crosses;
    logic hit;
    logic fill_last;
  } flcf_stat_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/flcf_ram.sv =====
module flcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/flcf_ctrl.sv =====
`include "flash_line_cache_fifo_unit_macros.svh"

module flcf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  flcf_pkg::flcf_stat_t stat,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output flcf_pkg::flcf_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_RDREQ = 2'd2;
  localparam logic [1:0] S_RD    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [flcf_pkg::STATUS_W-1:0] rd_status;
  logic [flcf_pkg::STATUS_W-1:0] rd_status_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    rd_status_next = rd_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.mode == flcf_pkg::MODE_FILL) begin
          if (!stat.fill_pending) begin
            state_next = S_IDLE;
          end else begin
            cmd.fill_wr = 1'b1;
            if (stat.fill_last) begin
              cmd.fill_end   = 1'b1;
              rd_status_next = flcf_pkg::ST_FILL_DONE;
              state_next     = S_RDREQ;
            end else begin
              state_next = S_IDLE;
            end
          end
        end else if (stat.fill_pending) begin
          state_next = S_IDLE;
        end else if (stat.out_of_range) begin
          if (out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = flcf_pkg::ST_RANGE;
            state_next     = S_IDLE;
          end
        end else if (stat.crosses) begin
          if (out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = flcf_pkg::ST_BYPASS;
            state_next     = S_IDLE;
          end
        end else if (stat.hit) begin
          cmd.hit_sel    = 1'b1;
          rd_status_next = flcf_pkg::ST_HIT;
          state_next     = S_RDREQ;
        end else if (out_free) begin
          cmd.miss       = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = flcf_pkg::ST_FILL_NEEDED;
          state_next     = S_IDLE;
        end
      end
      S_RDREQ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD;
      end
      S_RD: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = rd_status;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_status <= flcf_pkg::ST_HIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_status <= rd_status_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FLCF_ASSERT(a_no_overwrite, clk, rst, out_valid && out_stall, !cmd.out_load)
  `FLCF_ASSERT_NEXT(a_issue_then_read, clk, rst, cmd.rd_issue, state == S_RD)
  `FLCF_ASSERT(a_end_with_write, clk, rst, cmd.fill_end, cmd.fill_wr)

endmodule

// ===== sv/flcf_dp.sv =====
`include "flash_line_cache_fifo_unit_macros.svh"

module flcf_dp #(
  parameter int LINE_COUNT = flcf_pkg::LINE_COUNT_DEF,
  parameter int LINE_BYTES = flcf_pkg::LINE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  flcf_pkg::flcf_cmd_t                 cmd,
  output flcf_pkg::flcf_stat_t                stat,
  input  logic [flcf_pkg::ADDR_W-1:0]         flash_base,
  input  logic                                mode,
  input  logic [flcf_pkg::ADDR_W-1:0]         address,
  input  logic [flcf_pkg::SIZE_W-1:0]         read_size,
  input  logic [flcf_pkg::DATA_W-1:0]         fill_word,
  output logic [flcf_pkg::STATUS_W-1:0]       status,
  output logic [flcf_pkg::ADDR_W-1:0]         line_address,
  output logic [flcf_pkg::SLOT_W-1:0]         slot,
  output logic [flcf_pkg::OFFSET_W-1:0]       offset,
  output logic [flcf_pkg::DATA_W-1:0]         read_data
);

  localparam int OFFW       = $clog2(LINE_BYTES);
  localparam int OFFW1      = OFFW + 1;
  localparam int TAGW       = flcf_pkg::ADDR_W - OFFW;
  localparam int SLW        = $clog2(LINE_COUNT);
  localparam int WPL        = LINE_BYTES / 4;
  localparam int WW         = $clog2(WPL);
  localparam int HPL        = WPL / 2;
  localparam int BANK_DEPTH = LINE_COUNT * HPL;
  localparam int BAW        = $clog2(BANK_DEPTH);

  // captured request
  logic                          req_mode;
  logic [flcf_pkg::ADDR_W-1:0]   req_addr;
  logic [flcf_pkg::SIZE_W-1:0]   req_size;
  logic [flcf_pkg::DATA_W-1:0]   req_word;

  // line directory
  logic [LINE_COUNT-1:0]         line_valid;
  logic [TAGW-1:0]               line_tag [LINE_COUNT];

  // fill bookkeeping
  logic [SLW-1:0]                oldest;
  logic                          fill_pending;
  logic [WW-1:0]                 fill_count;
  logic [OFFW-1:0]               pend_off;
  logic [flcf_pkg::SIZE_W-1:0]   pend_size;
  logic [flcf_pkg::ADDR_W-1:0]   pend_base;

  // line being read for a hit or a completed fill
  logic [SLW-1:0]                cur_slot;
  logic [OFFW-1:0]               cur_off;
  logic [flcf_pkg::SIZE_W-1:0]   cur_size;
  logic [flcf_pkg::ADDR_W-1:0]   cur_base;

  logic [OFFW-1:0]               req_off;
  logic [TAGW-1:0]               req_tag;
  logic [flcf_pkg::ADDR_W-1:0]   req_base;
  logic [flcf_pkg::SIZE_W-1:0]   size_sat;
  logic [LINE_COUNT-1:0]         hit_vec;
  logic [SLW-1:0]                hit_slot;

  logic [BAW-1:0]                wr_addr;
  logic [WW-1:0]                 cur_word;
  logic [WW-1:0]                 next_word;
  logic [WW-1:0]                 even_idx;
  logic [BAW-1:0]                even_addr;
  logic [BAW-1:0]                odd_addr;
  logic [flcf_pkg::DATA_W-1:0]   even_q;
  logic [flcf_pkg::DATA_W-1:0]   odd_q;
  logic [flcf_pkg::DATA_W-1:0]   lo_word;
  logic [flcf_pkg::DATA_W-1:0]   hi_word;
  logic [2*flcf_pkg::DATA_W-1:0] pair_shift;
  logic [flcf_pkg::DATA_W-1:0]   gathered;

  assign size_sat = (read_size > flcf_pkg::SIZE_W'(flcf_pkg::MAX_READ)) ?
                    flcf_pkg::SIZE_W'(flcf_pkg::MAX_READ) : read_size;

  assign req_off  = req_addr[OFFW-1:0];
  assign req_tag  = req_addr[flcf_pkg::ADDR_W-1:OFFW];
  assign req_base = {req_tag, {OFFW{1'b0}}};

  always_comb begin
    hit_slot = '0;
    for (int s = 0; s < LINE_COUNT; s++) begin
      hit_vec[s] = line_valid[s] && (line_tag[s] == req_tag);
      if (hit_vec[s]) begin
        hit_slot = hit_slot | SLW'(s);
      end
    end
  end

  assign stat.mode         = req_mode;
  assign stat.fill_pending = fill_pending;
  assign stat.out_of_range = (req_addr < flash_base);
  assign stat.crosses      = ({1'b0, req_off} > (OFFW1'(LINE_BYTES) - OFFW1'(req_size)));
  assign stat.hit          = |hit_vec;
  assign stat.fill_last    = (fill_count == WW'(WPL - 1));

  // even/odd word banks so a four-byte read spanning two words takes one access
  assign wr_addr   = BAW'(BAW'(oldest) * BAW'(HPL)) + BAW'(fill_count >> 1);
  assign cur_word  = cur_off[OFFW-1:2];
  assign next_word = cur_word + 1'b1;
  assign even_idx  = cur_word[0] ? next_word : cur_word;
  assign even_addr = BAW'(BAW'(cur_slot) * BAW'(HPL)) + BAW'(even_idx >> 1);
  assign odd_addr  = BAW'(BAW'(cur_slot) * BAW'(HPL)) + BAW'(cur_word >> 1);

  flcf_ram #(
    .WIDTH (flcf_pkg::DATA_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk     (clk),
    .wr_en   (cmd.fill_wr && !fill_count[0]),
    .wr_addr (wr_addr),
    .wr_data (req_word),
    .rd_en   (cmd.rd_issue),
    .rd_addr (even_addr),
    .rd_data (even_q)
  );

  flcf_ram #(
    .WIDTH (flcf_pkg::DATA_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk     (clk),
    .wr_en   (cmd.fill_wr && fill_count[0]),
    .wr_addr (wr_addr),
    .wr_data (req_word),
    .rd_en   (cmd.rd_issue),
    .rd_addr (odd_addr),
    .rd_data (odd_q)
  );

  assign lo_word    = cur_word[0] ? odd_q : even_q;
  assign hi_word    = cur_word[0] ? even_q : odd_q;
  assign pair_shift = {hi_word, lo_word} >> {cur_off[1:0], 3'b000};
  assign gathered   = pair_shift[flcf_pkg::DATA_W-1:0] & flcf_pkg::size_mask(cur_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid   <= '0;
      oldest       <= '0;
      fill_pending <= 1'b0;
      fill_count   <= '0;
      pend_off     <= '0;
      pend_size    <= '0;
    end else begin
      if (cmd.miss) begin
        line_valid[oldest] <= 1'b0;
        fill_pending       <= 1'b1;
        fill_count         <= '0;
        pend_off           <= req_off;
        pend_size          <= req_size;
      end
      if (cmd.fill_wr && !cmd.fill_end) begin
        fill_count <= fill_count + 1'b1;
      end
      if (cmd.fill_end) begin
        line_valid[oldest] <= 1'b1;
        fill_pending       <= 1'b0;
        fill_count         <= '0;
        oldest             <= (oldest == SLW'(LINE_COUNT - 1)) ? '0 : oldest + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode <= mode;
      req_addr <= address;
      req_size <= size_sat;
      req_word <= fill_word;
    end
    if (cmd.miss) begin
      line_tag[oldest] <= req_tag;
      pend_base        <= req_base;
    end
    if (cmd.fill_end) begin
      cur_slot <= oldest;
      cur_off  <= pend_off;
      cur_size <= pend_size;
      cur_base <= pend_base;
    end
    if (cmd.hit_sel) begin
      cur_slot <= hit_slot;
      cur_off  <= req_off;
      cur_size <= req_size;
      cur_base <= req_base;
    end
    if (cmd.out_load) begin
      status <= cmd.out_status;
      case (cmd.out_status) inside
        flcf_pkg::ST_HIT, flcf_pkg::ST_FILL_DONE: begin
          line_address <= cur_base;
          slot         <= flcf_pkg::SLOT_W'(cur_slot);
          offset       <= flcf_pkg::OFFSET_W'(cur_off);
          read_data    <= gathered;
        end
        flcf_pkg::ST_FILL_NEEDED: begin
          line_address <= req_base;
          slot         <= flcf_pkg::SLOT_W'(oldest);
          offset       <= flcf_pkg::OFFSET_W'(req_off);
          read_data    <= '0;
        end
        default: begin
          line_address <= req_addr;
          slot         <= '0;
          offset       <= flcf_pkg::OFFSET_W'(req_off);
          read_data    <= '0;
        end
      endcase
    end
  end

  `FLCF_ASSERT(a_hit_onehot, clk, rst, 1'b1, $onehot0(hit_vec))

endmodule

// ===== sv/flash_line_cache_fifo_unit.sv =====
// Result: out_valid rises once EVAL loads the result register for miss, bypass and
//   out-of-range reads, and once RD loads it for hits and the fill word that completes a line.
// Issue: a new transfer is taken only back in IDLE, and an output stall can hold EVAL or RD;
//   the single-issue controller and the registered read of the line data banks set this.
// Reset (synchronous, rst high) clears valid bits, fill state, FIFO pointer and
//   flash_base; line data and tags need no clearing pass and are ready at once.
module flash_line_cache_fifo_unit #(
  parameter int LINE_COUNT = flcf_pkg::LINE_COUNT_DEF,
  parameter int LINE_BYTES = flcf_pkg::LINE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request / fill word channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [flcf_pkg::ADDR_W-1:0]       address,
  input  logic [flcf_pkg::SIZE_W-1:0]       read_size,
  input  logic [flcf_pkg::DATA_W-1:0]       fill_word,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [flcf_pkg::STATUS_W-1:0]     status,
  output logic [flcf_pkg::ADDR_W-1:0]       line_address,
  output logic [flcf_pkg::SLOT_W-1:0]       slot,
  output logic [flcf_pkg::OFFSET_W-1:0]     offset,
  output logic [flcf_pkg::DATA_W-1:0]       read_data,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [flcf_pkg::PADDR_W-1:0]      paddr,
  input  logic [flcf_pkg::DATA_W-1:0]       pwdata,
  output logic [flcf_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  // Structure:
  //   flcf_ctrl - sequencer. Takes one transfer at a time, sequences the
  //               directory update, line-data read and output register load.
  //   flcf_dp   - request capture, tag directory (parallel compares over all
  //               slots), FIFO pointer, fill counter, even/odd word banks and
  //               the result register.
  //
  // Flow per accepted transfer:
  //   IDLE  -> capture the transfer
  //   EVAL  -> range check, line-crossing check, tag lookup, or fill word write
  //   RDREQ -> issue bank reads (hit or finished fill only)
  //   RD    -> align bytes, load result register
  // A read arriving while a fill is pending, and a fill word with no fill
  // pending, are dropped without a result.

  flcf_pkg::flcf_cmd_t  cmd;
  flcf_pkg::flcf_stat_t stat;

  logic [flcf_pkg::ADDR_W-1:0]  flash_base;
  logic [flcf_pkg::PADDR_W-3:0] reg_index;
  logic                         reg_wr;

  // Register file: a single register, flash_base, at byte address 0.
  assign reg_index = paddr[flcf_pkg::PADDR_W-1:2];
  assign reg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (reg_index == flcf_pkg::REG_FLASH_BASE) ? flash_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base <= '0;
    end else if (reg_wr && (reg_index == flcf_pkg::REG_FLASH_BASE)) begin
      flash_base <= pwdata;
    end
  end

  flcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  flcf_dp #(
    .LINE_COUNT (LINE_COUNT),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .flash_base   (flash_base),
    .mode         (mode),
    .address      (address),
    .read_size    (read_size),
    .fill_word    (fill_word),
    .status       (status),
    .line_address (line_address),
    .slot         (slot),
    .offset       (offset),
    .read_data    (read_data)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Flash line cache testbench.
// A directed table runs first: range errors, line-crossing bypass, zero and
// oversized read sizes, reads and fill words that arrive at the wrong time,
// and fills at both ends of the address space. Random traffic follows, in
// phases with different flash window bases. Each phase mostly replays real
// miss/fill sequences over a small pool of lines so that hits and FIFO
// eviction happen often, with some noise mixed in.
// Every accepted transfer runs through a local cache predictor. Each result
// transfer is checked against the oldest predicted result.
module testbench;
  import flcf_pkg::*;

  localparam int LINES      = 8;
  localparam int LINE_WORDS = 8;
  localparam int SHOW_MAX   = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   line_address;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   read_data;
  } cache_result_t;

  // One row of the directed table. A row with a typed result overrides
  // the predictor's answer for that transfer.
  typedef struct {
    logic               mode;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  read_size;
    logic [DATA_W-1:0]  fill_word;
    bit                 typed;
    cache_result_t      want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                mode;
  logic [ADDR_W-1:0]   address;
  logic [SIZE_W-1:0]   read_size;
  logic [DATA_W-1:0]   fill_word;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   line_address;
  logic [SLOT_W-1:0]   slot;
  logic [OFFSET_W-1:0] offset;
  logic [DATA_W-1:0]   read_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  flash_line_cache_fifo_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Cache predictor state
  // ---------------------------------------------------------------------
  logic [ADDR_W-1:0]   window_base;
  bit                  slot_live [LINES];
  logic [26:0]         slot_line [LINES];
  logic [DATA_W-1:0]   slot_words [LINES][LINE_WORDS];
  logic [SLOT_W-1:0]   evict_ptr;
  bit                  filling;
  logic [2:0]          fill_beat;
  logic [OFFSET_W-1:0] hold_off;
  logic [SIZE_W-1:0]   hold_size;

  cache_result_t       awaited_results [$];
  int                  bad_count;
  int                  shown_count;

  // handshake between stimulus, receiver and scoreboard
  bit                  cur_typed;
  cache_result_t       cur_want;
  bit                  calm;
  bit                  hold_request;
  logic [26:0]         tag_pool [12];

  function automatic logic [DATA_W-1:0] pick_bytes(input logic [SLOT_W-1:0] s,
                                                   input logic [OFFSET_W-1:0] off,
                                                   input logic [SIZE_W-1:0] n);
    logic [DATA_W-1:0]   d;
    logic [OFFSET_W-1:0] pos;
    d = '0;
    for (int i = 0; i < int'(n); i++) begin
      pos = off + OFFSET_W'(i);  // wraps inside the line
      d[i*8 +: 8] = slot_words[s][pos[4:2]][pos[1:0]*8 +: 8];
    end
    return d;
  endfunction

  // Advances the predictor by one accepted transfer; returns 1 when the
  // transfer produces a result.
  function automatic bit predict_cache(input logic m, input logic [ADDR_W-1:0] a,
                                       input logic [SIZE_W-1:0] sz_in,
                                       input logic [DATA_W-1:0] w,
                                       output cache_result_t r);
    logic [SIZE_W-1:0]   sz;
    logic [OFFSET_W-1:0] off;
    logic [26:0]         tg;
    logic [SLOT_W-1:0]   s;
    bit                  found;
    r = '0;
    found = 1'b0;
    if (m == MODE_FILL) begin
      if (!filling) return 1'b0;  // stray fill word
      s = evict_ptr;
      slot_words[s][fill_beat] = w;
      if (fill_beat != 3'd7) begin
        fill_beat = fill_beat + 3'd1;
        return 1'b0;
      end
      // last word: line becomes live, FIFO pointer moves on
      fill_beat     = '0;
      filling       = 1'b0;
      slot_live[s]  = 1'b1;
      evict_ptr     = s + 1'b1;
      r.status       = ST_FILL_DONE;
      r.line_address = {slot_line[s], 5'd0};
      r.slot         = s;
      r.offset       = hold_off;
      r.read_data    = pick_bytes(s, hold_off, hold_size);
      return 1'b1;
    end
    if (filling) return 1'b0;  // reads are dropped while a line loads
    sz  = (sz_in > SIZE_W'(MAX_READ)) ? SIZE_W'(MAX_READ) : sz_in;
    off = a[4:0];
    tg  = a[31:5];
    r.offset = off;
    if (a < window_base) begin
      r.status       = ST_RANGE;
      r.line_address = a;
      return 1'b1;
    end
    if (int'(off) > 32 - int'(sz)) begin
      r.status       = ST_BYPASS;
      r.line_address = a;
      return 1'b1;
    end
    r.line_address = {tg, 5'd0};
    for (int i = LINES - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_line[i] == tg) begin
        found       = 1'b1;
        r.status    = ST_HIT;
        r.slot      = SLOT_W'(i);
        r.read_data = pick_bytes(SLOT_W'(i), off, sz);
      end
    end
    if (found) return 1'b1;
    // miss: claim the oldest slot and wait for its words
    s = evict_ptr;
    slot_live[s] = 1'b0;
    slot_line[s] = tg;
    filling      = 1'b1;
    fill_beat    = '0;
    hold_off     = off;
    hold_size    = sz;
    r.status     = ST_FILL_NEEDED;
    r.slot       = s;
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    bad_count++;
    if (shown_count < SHOW_MAX) begin
      shown_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard: input transfers feed the predictor, result transfers are
  // checked against the oldest expectation. One process, so the order
  // of the two steps is fixed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard_p
    cache_result_t want;
    cache_result_t got;
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) begin
        if (predict_cache(mode, address, read_size, fill_word, want)) begin
          if (cur_typed) want = cur_want;
          awaited_results.push_back(want);
        end
      end
      if (out_valid === 1'b1 && !out_stall) begin
        got = '{status, line_address, slot, offset, read_data};
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("unexpected result st=%0d la=%h slot=%0d off=%0d data=%h",
                               got.status, got.line_address, got.slot, got.offset,
                               got.read_data));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.line_address !== want.line_address ||
              got.slot !== want.slot || got.offset !== want.offset ||
              got.read_data !== want.read_data)
            flag_error($sformatf({"exp st=%0d la=%h slot=%0d off=%0d data=%h, ",
                                  "got st=%0d la=%h slot=%0d off=%0d data=%h"},
                                 want.status, want.line_address, want.slot, want.offset,
                                 want.read_data, got.status, got.line_address, got.slot,
                                 got.offset, got.read_data));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, one long hold-off on request,
  // nothing once the run is in its calm tail.
  // ---------------------------------------------------------------------
  initial begin : receiver_p
    int pick;
    int len;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else if (hold_request) begin
        // long hold so the block backs up and stalls its input
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        len  = (pick == 9) ? 100 : $urandom_range(1, 16);
        out_stall <= (pick < 3);
        repeat (len) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic m, input logic [ADDR_W-1:0] a,
                           input logic [SIZE_W-1:0] sz, input logic [DATA_W-1:0] w);
    in_valid  <= 1'b1;
    mode      <= m;
    address   <= a;
    read_size <= sz;
    fill_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [DATA_W-1:0] wd, output logic [DATA_W-1:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= wd;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain, then move the flash window and refresh the line pool.
  task automatic set_window(input logic [ADDR_W-1:0] base);
    logic [DATA_W-1:0] rd;
    logic [31:0]       base_tag;
    logic [31:0]       t;
    int                k;
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    // a fill word with no result may still be in flight
    repeat (8) @(negedge clk);
    reg_access(1'b1, {REG_FLASH_BASE, 2'b00}, base, rd);
    window_base = base;
    reg_access(1'b0, {REG_FLASH_BASE, 2'b00}, '0, rd);
    if (rd !== base)
      flag_error($sformatf("flash_base readback exp %h got %h", base, rd));
    base_tag = base >> 5;
    tag_pool[0] = base_tag[26:0];
    for (int i = 1; i < 12; i++) begin
      if (i < 6) begin
        k = $urandom_range(0, 15);
        t = base_tag + k;
        if (t > 32'h07FF_FFFF) t = 32'h07FF_FFFF - k;
      end else begin
        t = $urandom_range(base_tag, 32'h07FF_FFFF);
      end
      tag_pool[i] = t[26:0];
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int          r;
    int          lo;
    logic [26:0] tg;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      // pool line: mostly in range, so hits and evictions happen
      tg = tag_pool[$urandom_range(0, 11)];
      lo = (tg == window_base[31:5]) ? int'(window_base[4:0]) : 0;
      return {tg, 5'($urandom_range(lo, 31))};
    end
    if (r < 8 && window_base != 0) return $urandom_range(0, window_base - 1);
    return $urandom;
  endfunction

  // Random traffic; n counts transfers the block does not drop.
  task automatic run_random(input int n, inout int sent);
    int                done;
    bit                sender_idles;
    logic              m;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] sz;
    logic [DATA_W-1:0] w;
    done = 0;
    sender_idles = 1'b1;
    while (done < n) begin
      if (filling) m = ($urandom_range(0, 99) < 93) ? MODE_FILL : MODE_READ;
      else         m = ($urandom_range(0, 99) < 4)  ? MODE_FILL : MODE_READ;
      if ((m == MODE_FILL) == filling) done++;
      a  = pick_address();
      sz = $urandom_range(0, 7);
      w  = $urandom;
      sent++;
      if (sent == 300) hold_request = 1'b1;
      send_item(m, a, sz, w);
      if (!calm && sender_idles && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      if (done % 128 == 0) sender_idles = ($urandom_range(0, 2) != 0);
    end
  endtask

  function automatic stim_row_t mk_row(input logic m, input logic [ADDR_W-1:0] a,
                                       input logic [SIZE_W-1:0] sz,
                                       input logic [DATA_W-1:0] w, input bit typed,
                                       input logic [STATUS_W-1:0] st,
                                       input logic [ADDR_W-1:0] la,
                                       input logic [SLOT_W-1:0] sl,
                                       input logic [OFFSET_W-1:0] off,
                                       input logic [DATA_W-1:0] d);
    stim_row_t row;
    row.mode      = m;
    row.address   = a;
    row.read_size = sz;
    row.fill_word = w;
    row.typed     = typed;
    row.want      = '{st, la, sl, off, d};
    return row;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus_p
    stim_row_t rows [$];
    int        sent;
    rst = 1'b1;
    in_valid = 1'b0; mode = MODE_READ; address = '0; read_size = '0; fill_word = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur_typed = 1'b0; cur_want = '0; calm = 1'b0; hold_request = 1'b0;
    bad_count = 0; shown_count = 0; sent = 0;
    // predictor reset state
    window_base = '0; evict_ptr = '0; filling = 1'b0; fill_beat = '0;
    hold_off = '0; hold_size = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_window(32'h0000_1000);

    // directed table; fill bytes of the first line equal their offsets
    rows.push_back(mk_row(MODE_READ, 32'h0000_0000, 3'd4, '0, 1,
                          ST_RANGE, 32'h0000_0000, 3'd0, 5'd0, '0));
    rows.push_back(mk_row(MODE_READ, 32'h0000_0FFF, 3'd1, '0, 1,
                          ST_RANGE, 32'h0000_0FFF, 3'd0, 5'd31, '0));
    // crosses line end
    rows.push_back(mk_row(MODE_READ, 32'h0000_101E, 3'd4, '0, 1,
                          ST_BYPASS, 32'h0000_101E, 3'd0, 5'd30, '0));
    // size zero at the last byte never bypasses
    rows.push_back(mk_row(MODE_READ, 32'h0000_101F, 3'd0, '0, 1,
                          ST_FILL_NEEDED, 32'h0000_1000, 3'd0, 5'd31, '0));
    // read during a fill is dropped
    rows.push_back(mk_row(MODE_READ, 32'h0000_2000, 3'd4, '0, 0, '0, '0, '0, '0, '0));
    for (int k = 0; k < 8; k++)
      rows.push_back(mk_row(MODE_FILL, '0, '0, 32'h0302_0100 + k * 32'h0404_0404,
                            k == 7, ST_FILL_DONE, 32'h0000_1000, 3'd0, 5'd31, '0));
    rows.push_back(mk_row(MODE_READ, 32'h0000_1000, 3'd4, '0, 1,
                          ST_HIT, 32'h0000_1000, 3'd0, 5'd0, 32'h0302_0100));
    // size seven saturates to four
    rows.push_back(mk_row(MODE_READ, 32'h0000_101C, 3'd7, '0, 1,
                          ST_HIT, 32'h0000_1000, 3'd0, 5'd28, 32'h1F1E_1D1C));
    rows.push_back(mk_row(MODE_READ, 32'h0000_101E, 3'd2, '0, 1,
                          ST_HIT, 32'h0000_1000, 3'd0, 5'd30, 32'h0000_1F1E));
    // stray fill word
    rows.push_back(mk_row(MODE_FILL, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 0,
                          '0, '0, '0, '0, '0));
    rows.push_back(mk_row(MODE_READ, 32'hFFFF_FFFF, 3'd1, '0, 1,
                          ST_FILL_NEEDED, 32'hFFFF_FFE0, 3'd1, 5'd31, '0));
    for (int k = 0; k < 8; k++)
      rows.push_back(mk_row(MODE_FILL, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, k == 7,
                            ST_FILL_DONE, 32'hFFFF_FFE0, 3'd1, 5'd31, 32'h0000_00FF));
    rows.push_back(mk_row(MODE_READ, 32'hFFFF_FFFC, 3'd4, '0, 1,
                          ST_HIT, 32'hFFFF_FFE0, 3'd1, 5'd28, 32'hFFFF_FFFF));
    rows.push_back(mk_row(MODE_READ, 32'hFFFF_FFFD, 3'd4, '0, 1,
                          ST_BYPASS, 32'hFFFF_FFFD, 3'd0, 5'd29, '0));

    foreach (rows[i]) begin
      cur_typed = rows[i].typed;
      cur_want  = rows[i].want;
      send_item(rows[i].mode, rows[i].address, rows[i].read_size, rows[i].fill_word);
    end
    cur_typed = 1'b0;

    // random phases over several window bases, extremes included
    set_window(32'h0000_0000);
    run_random(420, sent);
    set_window(32'h4000_0000);
    run_random(420, sent);
    set_window($urandom);
    run_random(420, sent);
    set_window(32'hFFFF_FFFF);
    run_random(80, sent);
    set_window(32'h8000_0010);
    run_random(420, sent);
    calm = 1'b1;  // full-rate tail: no gaps, no stalls
    run_random(200, sent);

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (bad_count == 0 && awaited_results.size() == 0)
      $display("flash_line_cache_fifo_unit regression: pass");
    else
      $display("flash_line_cache_fifo_unit regression: fail");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog_p
    #5_000_000;
    $display("flash_line_cache_fifo_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/flcf_pkg.sv
sv/flcf_ram.sv
sv/flcf_ctrl.sv
sv/flcf_dp.sv
sv/flash_line_cache_fifo_unit.sv
test/testbench.sv
